FILE: design/tmh_pkg.sv
// Shared types and constants for the triangle mesh point hit test.
// Used by every module of the block except tmh_ram; depends on nothing.
`default_nettype none
package tmh_pkg;

  localparam int COORD_BITS  = 16;
  localparam int TRI_DEPTH   = 256;
  localparam int IDX_BITS    = $clog2(TRI_DEPTH);
  localparam int CNT_BITS    = 9;
  localparam int SLOT_BITS   = 8;
  localparam int CORNER_BITS = 2 * COORD_BITS;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int EDGE_W = PROD_W + 1;
  localparam int AREA_W = EDGE_W + 2;
  localparam int CMP_W  = AREA_W + 4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input tdata layout, lowest bit first.
  localparam int IN_FIELDS_W = SLOT_BITS + 8 * COORD_BITS + 1;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RESULT
  } bk_state_t;

  typedef struct packed {
    kind_t                kind;
    logic [SLOT_BITS-1:0] slot;
    coord_t               ax;
    coord_t               ay;
    coord_t               bx;
    coord_t               by;
    coord_t               cx;
    coord_t               cy;
    coord_t               px;
    coord_t               py;
    logic                 loose;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage
`default_nettype wire

FILE: design/tmh_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module tmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                        wdata,
  input  wire                                     re,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/tmh_front.sv
// Front end: unpacks and classifies input items into a short queue.
// Depends on tmh_pkg.
`default_nettype none
module tmh_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [tmh_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                              in_tuser,
  input  wire                              q_pop,
  output tmh_pkg::qhead_t                  q_head
);
  import tmh_pkg::*;

  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  item_t             item_in;
  logic              push;
  logic              pop;

  always_comb begin
    item_in.kind  = in_tuser ? KIND_QUERY : KIND_WRITE;
    item_in.slot  = in_tdata[SLOT_BITS-1:0];
    item_in.ax    = in_tdata[SLOT_BITS + 0*COORD_BITS +: COORD_BITS];
    item_in.ay    = in_tdata[SLOT_BITS + 1*COORD_BITS +: COORD_BITS];
    item_in.bx    = in_tdata[SLOT_BITS + 2*COORD_BITS +: COORD_BITS];
    item_in.by    = in_tdata[SLOT_BITS + 3*COORD_BITS +: COORD_BITS];
    item_in.cx    = in_tdata[SLOT_BITS + 4*COORD_BITS +: COORD_BITS];
    item_in.cy    = in_tdata[SLOT_BITS + 5*COORD_BITS +: COORD_BITS];
    item_in.px    = in_tdata[SLOT_BITS + 6*COORD_BITS +: COORD_BITS];
    item_in.py    = in_tdata[SLOT_BITS + 7*COORD_BITS +: COORD_BITS];
    item_in.loose = in_tdata[SLOT_BITS + 8*COORD_BITS];
  end

  assign in_tready    = (cnt_r != QCNT_W'(QDEPTH));
  assign push         = in_tvalid && in_tready;
  assign pop          = q_pop && (cnt_r != '0);
  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

FILE: design/tmh_back.sv
// Back end: triangle table RAMs, scan sequencer, edge function pipeline
// and result register. Depends on tmh_pkg and tmh_ram.
`default_nettype none
module tmh_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [tmh_pkg::CNT_BITS-1:0]     cfg_wr_data,
  input  tmh_pkg::qhead_t                  q_head,
  output logic                             q_pop,
  output logic                             res_valid,
  output logic                             res_inside,
  input  wire                              res_ready
);
  import tmh_pkg::*;

  bk_state_t           state_r, state_nxt;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] idx_r, idx_nxt;
  logic [CNT_BITS-1:0] lim_r, lim_nxt;
  logic                hit_r, hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_res_r, out_res_nxt;
  coord_t              px_r, py_r;
  logic                loose_r;
  logic                load_q;

  logic                   ram_we;
  logic                   ram_re;
  logic [CORNER_BITS-1:0] rd_a, rd_b, rd_c;

  logic v1_r, v2_r, v3_r, v4_r;

  // table write and scan read share the sequencer
  tmh_ram #(.WIDTH(CORNER_BITS), .DEPTH(TRI_DEPTH)) u_ram_a (
    .clk(clk), .we(ram_we), .waddr(q_head.item.slot[IDX_BITS-1:0]),
    .wdata({q_head.item.ay, q_head.item.ax}),
    .re(ram_re), .raddr(idx_r[IDX_BITS-1:0]), .rdata(rd_a)
  );
  tmh_ram #(.WIDTH(CORNER_BITS), .DEPTH(TRI_DEPTH)) u_ram_b (
    .clk(clk), .we(ram_we), .waddr(q_head.item.slot[IDX_BITS-1:0]),
    .wdata({q_head.item.by, q_head.item.bx}),
    .re(ram_re), .raddr(idx_r[IDX_BITS-1:0]), .rdata(rd_b)
  );
  tmh_ram #(.WIDTH(CORNER_BITS), .DEPTH(TRI_DEPTH)) u_ram_c (
    .clk(clk), .we(ram_we), .waddr(q_head.item.slot[IDX_BITS-1:0]),
    .wdata({q_head.item.cy, q_head.item.cx}),
    .re(ram_re), .raddr(idx_r[IDX_BITS-1:0]), .rdata(rd_c)
  );

  // stage 1: corner deltas and products
  logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb, dxc, dyc;
  logic signed [PROD_W-1:0] m_r [6];

  always_comb begin
    dxa = DIFF_W'(coord_t'(rd_a[COORD_BITS-1:0]))           - DIFF_W'(px_r);
    dya = DIFF_W'(coord_t'(rd_a[CORNER_BITS-1:COORD_BITS])) - DIFF_W'(py_r);
    dxb = DIFF_W'(coord_t'(rd_b[COORD_BITS-1:0]))           - DIFF_W'(px_r);
    dyb = DIFF_W'(coord_t'(rd_b[CORNER_BITS-1:COORD_BITS])) - DIFF_W'(py_r);
    dxc = DIFF_W'(coord_t'(rd_c[COORD_BITS-1:0]))           - DIFF_W'(px_r);
    dyc = DIFF_W'(coord_t'(rd_c[CORNER_BITS-1:COORD_BITS])) - DIFF_W'(py_r);
  end

  // stage 2: edge functions; stage 3: doubled area
  logic signed [EDGE_W-1:0] e_r  [3];
  logic signed [EDGE_W-1:0] e3_r [3];
  logic signed [AREA_W-1:0] area_r;

  always_ff @(posedge clk) begin
    m_r[0] <= dxb * dyc;
    m_r[1] <= dyb * dxc;
    m_r[2] <= dxc * dya;
    m_r[3] <= dyc * dxa;
    m_r[4] <= dxa * dyb;
    m_r[5] <= dya * dxb;
    e_r[0] <= EDGE_W'(m_r[0]) - EDGE_W'(m_r[1]);
    e_r[1] <= EDGE_W'(m_r[2]) - EDGE_W'(m_r[3]);
    e_r[2] <= EDGE_W'(m_r[4]) - EDGE_W'(m_r[5]);
    e3_r   <= e_r;
    area_r <= AREA_W'(e_r[0]) + AREA_W'(e_r[1]) + AREA_W'(e_r[2]);
  end

  // stage 4: sign-normalize and bound checks
  logic                    neg;
  logic signed [CMP_W-1:0] mag, mag6;
  logic signed [CMP_W-1:0] ef  [3];
  logic signed [CMP_W-1:0] ef5 [3];
  logic [2:0]              ok;
  logic                    hit_now;

  always_comb begin
    neg  = area_r[AREA_W-1];
    mag  = neg ? -CMP_W'(area_r) : CMP_W'(area_r);
    mag6 = (mag <<< 2) + (mag <<< 1);
    for (int i = 0; i < 3; i++) begin
      ef[i]  = neg ? -CMP_W'(e3_r[i]) : CMP_W'(e3_r[i]);
      ef5[i] = (ef[i] <<< 2) + ef[i];
      if (loose_r) begin
        ok[i] = (ef5[i] >= -mag) && (ef5[i] <= mag6);
      end else begin
        ok[i] = (ef[i] >= 0) && (ef[i] <= mag);
      end
    end
    hit_now = v4_r && (area_r != '0) && (&ok);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    hit_nxt       = hit_r | hit_now;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    load_q        = 1'b0;
    if (out_valid_r && res_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          if (q_head.item.kind == KIND_WRITE) begin
            ram_we = 1'b1;
          end else begin
            load_q    = 1'b1;
            idx_nxt   = '0;
            hit_nxt   = 1'b0;
            lim_nxt   = (count_r > CNT_BITS'(TRI_DEPTH)) ? CNT_BITS'(TRI_DEPTH) : count_r;
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (idx_r < lim_r) begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else if (!(v1_r || v2_r || v3_r || v4_r)) begin
          state_nxt = BK_RESULT;
        end
      end
      BK_RESULT: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = hit_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      lim_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      lim_r       <= lim_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= ram_re;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (load_q) begin
      px_r    <= q_head.item.px;
      py_r    <= q_head.item.py;
      loose_r <= q_head.item.loose;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_inside = out_res_r;

endmodule
`default_nettype wire

FILE: design/triangle_mesh_point_hit_test.sv
// A triangle write passes through the queue and is written into the table when the idle
// sequencer pops it. A query leaves the queue the same way; the scan then reads
// min(triangle_count, 256) stored triangles, one per cycle, through a 4-stage pipe and
// then raises out_tvalid. No item is popped while a query is in progress, so a new query
// waits until the previous result is registered; writes go one per cycle while idle.
// Reset (synchronous, rst_n low) clears the queue, sequencer, result register
// and triangle_count; table contents are undefined until written.
`default_nettype none
module triangle_mesh_point_hit_test (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [tmh_pkg::CNT_BITS-1:0]     cfg_wr_data,   // triangle_count
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // slot[7:0], corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x,
  // corner_c_y, point_x, point_y (16 bits each from bit 8), loose[136], zero pad
  input  wire  [tmh_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                              in_tuser,      // operation
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [tmh_pkg::OUT_TDATA_W-1:0]  out_tdata      // inside_res[0], zero pad
);
  import tmh_pkg::*;

  qhead_t q_head;
  logic   q_pop;
  logic   res_inside;

  tmh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  tmh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .res_valid   (out_tvalid),
    .res_inside  (res_inside),
    .res_ready   (out_tready)
  );

  assign out_tdata = {(OUT_TDATA_W - 1)'(0), res_inside};

endmodule
`default_nettype wire

FILE: design/tmh_checker.sv
// Port-level checks for the triangle mesh point hit test, bound to the top.
// Depends on tmh_pkg.
`default_nettype none
module tmh_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [tmh_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tmh_pkg::*;

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // result is held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // only the answer bit may be set
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("result padding not zero");

  // queue is ready right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind triangle_mesh_point_hit_test tmh_checker u_tmh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: bench/tb.sv
// Testbench for triangle_mesh_point_hit_test: loads triangles, queries points and checks
// every answer against an exact edge-function predictor kept inside the bench.
// Depends on tmh_pkg and the top-level RTL only.
module tb;
  import tmh_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy;
  } triangle_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CNT_BITS-1:0]    cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  triangle_t           mesh [TRI_DEPTH];
  logic [CNT_BITS-1:0] mesh_count;
  bit                  answer_q [$];

  int mismatches    = 0;
  int n_writes      = 0;
  int n_queries     = 0;
  int n_hits        = 0;
  int n_settings    = 0;
  int n_random      = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int stall_left    = 0;
  int idle_cycles   = 0;

  triangle_mesh_point_hit_test i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint edge_fn(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
    return (qx - px) * (ry - py) - (qy - py) * (rx - px);
  endfunction

  function automatic bit weight_ok(longint e, longint area, bit loose);
    if (loose) return (5 * e >= -area) && (5 * e <= 6 * area);
    return (e >= 0) && (e <= area);
  endfunction

  function automatic bit encloses(triangle_t t, coord_t px, coord_t py, bit loose);
    longint x, y, ea, eb, ec, area;
    x    = px;
    y    = py;
    ea   = edge_fn(x, y, t.bx, t.by, t.cx, t.cy);
    eb   = edge_fn(x, y, t.cx, t.cy, t.ax, t.ay);
    ec   = edge_fn(x, y, t.ax, t.ay, t.bx, t.by);
    area = ea + eb + ec;
    if (area == 0) return 1'b0;
    if (area < 0) begin
      area = -area;
      ea   = -ea;
      eb   = -eb;
      ec   = -ec;
    end
    return weight_ok(ea, area, loose) && weight_ok(eb, area, loose) &&
           weight_ok(ec, area, loose);
  endfunction

  function automatic int scan_depth();
    return (mesh_count > TRI_DEPTH) ? TRI_DEPTH : int'(mesh_count);
  endfunction

  function automatic bit point_hits_table(coord_t px, coord_t py, bit loose);
    for (int i = 0; i < scan_depth(); i++)
      if (encloses(mesh[i], px, py, loose)) return 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'(rand_span(-32768, 32767));
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic triangle_t rand_triangle();
    triangle_t t;
    int        x0, y0, dx, dy, step;
    case ($urandom_range(0, 9))
      0, 1: begin
        t.ax = rand_coord(); t.ay = rand_coord();
        t.bx = rand_coord(); t.by = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord();
      end
      2: begin
        // collinear corners, sometimes all the same point
        x0 = rand_span(-20000, 20000); y0 = rand_span(-20000, 20000);
        dx = rand_span(-5000, 5000);   dy = rand_span(-5000, 5000);
        if ($urandom_range(0, 3) == 0) begin
          dx = 0; dy = 0;
        end
        t.ax = coord_t'(x0);          t.ay = coord_t'(y0);
        t.bx = coord_t'(x0 + dx);     t.by = coord_t'(y0 + dy);
        t.cx = coord_t'(x0 + 2 * dx); t.cy = coord_t'(y0 + 2 * dy);
      end
      default: begin
        // corners on a lattice of 20ths so weighted points land exactly on bounds
        x0   = rand_span(-26000, 26000); y0 = rand_span(-26000, 26000);
        step = 20 * rand_span(1, 10);
        t.ax = coord_t'(x0 + step * rand_span(-30, 30));
        t.ay = coord_t'(y0 + step * rand_span(-30, 30));
        t.bx = coord_t'(x0 + step * rand_span(-30, 30));
        t.by = coord_t'(y0 + step * rand_span(-30, 30));
        t.cx = coord_t'(x0 + step * rand_span(-30, 30));
        t.cy = coord_t'(y0 + step * rand_span(-30, 30));
      end
    endcase
    return t;
  endfunction

  function automatic void near_point(output coord_t px, output coord_t py);
    triangle_t t;
    int        wa, wb, wc;
    if (scan_depth() == 0 || $urandom_range(0, 4) == 0) begin
      px = rand_coord();
      py = rand_coord();
      return;
    end
    t = mesh[$urandom_range(0, scan_depth() - 1)];
    if ($urandom_range(0, 1) == 0) begin
      wa = rand_span(0, 20);
      wb = rand_span(0, 20 - wa);
    end else begin
      wa = rand_span(-5, 25);
      wb = rand_span(-5, 25);
    end
    wc = 20 - wa - wb;
    px = clamp_coord((wa * longint'(t.ax) + wb * longint'(t.bx) + wc * longint'(t.cx)) / 20);
    py = clamp_coord((wa * longint'(t.ay) + wb * longint'(t.by) + wc * longint'(t.cy)) / 20);
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_item(kind_t op, logic [SLOT_BITS-1:0] slot, triangle_t t,
                           coord_t px, coord_t py, logic loose);
    bit hit;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tdata  = IN_TDATA_W'({loose, py, px, t.cy, t.cx, t.by, t.bx, t.ay, t.ax, slot});
    in_tuser  = op;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == KIND_WRITE) begin
      mesh[slot] = t;
      n_writes++;
    end else begin
      hit = point_hits_table(px, py, loose);
      answer_q.push_back(hit);
      n_queries++;
      n_hits += hit;
    end
    @(negedge clk);
  endtask

  task automatic write_triangle(logic [SLOT_BITS-1:0] slot, triangle_t t);
    send_item(KIND_WRITE, slot, t, rand_coord(), rand_coord(), 1'($urandom));
  endtask

  task automatic query_point(coord_t px, coord_t py, logic loose);
    logic [SLOT_BITS-1:0] noise_slot;
    noise_slot = SLOT_BITS'($urandom);
    send_item(KIND_QUERY, noise_slot, rand_triangle(), px, py, loose);
  endtask

  task automatic random_query();
    coord_t px, py;
    near_point(px, py);
    query_point(px, py, 1'($urandom));
  endtask

  task automatic random_item();
    logic [SLOT_BITS-1:0] slot;
    slot = SLOT_BITS'($urandom);
    if ($urandom_range(0, 3) == 0) write_triangle(slot, rand_triangle());
    else random_query();
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // trailing writes have no answer to wait for, so give them time to land
  task automatic set_count(int value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = CNT_BITS'(value);
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    mesh_count  = CNT_BITS'(value);
    n_settings++;
  endtask

  function automatic triangle_t make_triangle(int ax, int ay, int bx, int by, int cx, int cy);
    triangle_t t;
    t.ax = coord_t'(ax); t.ay = coord_t'(ay);
    t.bx = coord_t'(bx); t.by = coord_t'(by);
    t.cx = coord_t'(cx); t.cy = coord_t'(cy);
    return t;
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin : check_answer
    bit want;
    if (rst_n && out_tvalid && out_tready) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("answer %0b with no query pending", out_tdata[0]));
      end else begin
        want = answer_q.pop_front();
        if (out_tdata[0] !== want)
          report_mismatch($sformatf("inside_res %b, predicted %0b", out_tdata[0], want));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 99) < out_stall_pct)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_empty_table();
    set_count(0);
    query_point(coord_t'(0), coord_t'(0), 1'b0);
    query_point(coord_t'(-32768), coord_t'(32767), 1'b1);
  endtask

  task automatic test_basic_shapes();
    write_triangle(0, make_triangle(0, 0, 100, 0, 0, 100));              // counterclockwise
    write_triangle(1, make_triangle(1000, 1000, 1000, 1100, 1100, 1000)); // clockwise
    write_triangle(2, make_triangle(5000, 5000, 6000, 6000, 7000, 7000)); // degenerate
    write_triangle(3, make_triangle(-32768, -32768, 32767, -32768, -32768, 32767));
    set_count(3);
    query_point(coord_t'(0), coord_t'(0), 1'b0);       // on a corner
    query_point(coord_t'(50), coord_t'(50), 1'b0);     // on an edge
    query_point(coord_t'(-10), coord_t'(50), 1'b0);    // just outside
    query_point(coord_t'(-10), coord_t'(50), 1'b1);    // inside the loose margin
    query_point(coord_t'(-30), coord_t'(50), 1'b1);    // beyond the loose margin
    query_point(coord_t'(1050), coord_t'(1020), 1'b0);
    query_point(coord_t'(6000), coord_t'(6000), 1'b1); // on the flat triangle
    set_count(4);
    query_point(coord_t'(-32768), coord_t'(-32768), 1'b0);
    query_point(coord_t'(32767), coord_t'(32767), 1'b1);
    set_count(1);
    query_point(coord_t'(1050), coord_t'(1020), 1'b0); // clockwise one not examined
  endtask

  task automatic test_full_table();
    for (int s = 0; s < TRI_DEPTH; s++) write_triangle(SLOT_BITS'(s), rand_triangle());
    set_count(TRI_DEPTH);
    repeat (4) random_query();
    set_count(511);
    repeat (3) random_query();
    set_count(300);
    repeat (2) random_query();
  endtask

  task automatic test_random_mix();
    int pick, len;
    while (n_random < 400) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      set_count(0);
      else if (pick <= 2) set_count(rand_span(250, 511));
      else if (pick <= 5) set_count(rand_span(17, 64));
      else                set_count(rand_span(1, 16));
      in_gap_pct    = 15 * $urandom_range(0, 2);
      out_stall_pct = 15 * $urandom_range(0, 2);
      len = rand_span(20, 50);
      for (int k = 0; k < len; k++) begin
        if (k == len / 2) drain_results();
        random_item();
        n_random++;
      end
    end
  endtask

  task automatic test_steady_stream();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_count(rand_span(4, 12));
    repeat (80) random_item();
  endtask

  initial begin
    mesh_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_basic_shapes();
    in_gap_pct    = 20;
    out_stall_pct = 20;
    test_full_table();
    test_random_mix();
    test_steady_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d triangle writes and %0d point queries, %0d of them predicted hits,",
             n_writes, n_queries, n_hits);
    $display("over %0d triangle_count settings from 0 up to 511.", n_settings);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
